// ===== sv/i2cec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the I2C EEPROM transfer chunker.
// No dependencies; every other file of the block imports this package.
package i2cec_pkg;

    localparam int CURSOR_W      = 20;
    localparam int LEN_W         = 20;
    localparam int OFFSET_W      = 19;
    localparam int SLAVE_W       = 7;
    localparam int WORD_W        = 16;
    localparam int PAGE_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int OP_W          = 2;
    localparam int DEF_ADDR_BITS = 19;

    localparam logic [OP_W-1:0] OP_START_RD = 2'd0;
    localparam logic [OP_W-1:0] OP_START_WR = 2'd1;

    localparam logic [STATUS_W-1:0] STS_CHUNK   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_XFER = 2'd2;

    localparam logic [SLAVE_W-1:0] DEFAULT_SLAVE = 7'h50;

    // page offset remainder: bits of the cursor consumed per cycle
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = CURSOR_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_BASE_SLAVE = 3'd0;
    localparam logic [2:0] REG_CAPACITY   = 3'd1;
    localparam logic [2:0] REG_PG_BYTES   = 3'd2;
    localparam logic [2:0] REG_WORD_BYTES = 3'd3;
    localparam logic [2:0] REG_BLOCK_BITS = 3'd4;

    localparam logic [SLAVE_W-1:0]  RST_BASE_SLAVE = 7'd80;
    localparam logic [CURSOR_W-1:0] RST_CAPACITY   = 20'd1024;
    localparam logic [PAGE_W-1:0]   RST_PG_BYTES   = 8'd16;
    localparam logic [1:0]          RST_WORD_BYTES = 2'd1;
    localparam logic [1:0]          RST_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic [SLAVE_W-1:0]  base_dev_addr;
        logic [CURSOR_W-1:0] capacity;
        logic [PAGE_W-1:0]   pg_bytes;
        logic [1:0]          addr_bytes;
        logic [1:0]          block_select_bits;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic calc;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_chunk;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/i2c_eeprom_transfer_chunker_core.sv =====
`timescale 1ns / 1ps
// EEPROM transfer chunker: splits linear EEPROM reads and writes into I2C chunk commands. An
// item passes through acceptance, range check, the page offset remainder unit (4 cursor bits
// per cycle), chunk sizing and the output load; the output load waits while the result side
// is not ready. Rejected starts and "next" items with no transfer running skip the remainder
// and sizing. The next item is accepted as soon as the result is in the output register,
// even while it still waits to be taken. Write registers only while the block is idle.
// Top level; depends on i2cec_pkg, i2cec_cfg, i2cec_ctrl and i2cec_dp.
module i2c_eeprom_transfer_chunker_core import i2cec_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    localparam int S_TDATA_W = ((ADDR_BITS + LEN_W + 7) / 8) * 8,
    localparam int M_DATA_BITS = SLAVE_W + WORD_W + LEN_W + OFFSET_W,
    localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // start_addr, length
    input  logic [OP_W-1:0]       s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // dev_addr, mem_addr, chunk_len, buffer_offset
    output logic [STATUS_W:0]     m_tuser,   // status, is_write
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [STATUS_W-1:0] o_status;
    logic [SLAVE_W-1:0]  o_slave;
    logic [WORD_W-1:0]   o_word;
    logic [LEN_W-1:0]    o_chunk;
    logic [OFFSET_W-1:0] o_offset;
    logic                o_write;

    i2cec_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2cec_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .cmd               (cmd),
        .stat              (stat),
        .in_opcode         (s_tuser),
        .in_start_addr     (s_tdata[ADDR_BITS-1:0]),
        .in_length         (s_tdata[ADDR_BITS +: LEN_W]),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_status        (o_status),
        .out_dev_addr      (o_slave),
        .out_mem_addr      (o_word),
        .out_chunk_len     (o_chunk),
        .out_buffer_offset (o_offset),
        .out_is_write      (o_write),
        .out_last          (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({o_offset, o_chunk, o_word, o_slave});
    assign m_tuser = {o_write, o_status};

endmodule

// ===== sv/i2cec_cfg.sv =====
`timescale 1ns / 1ps
// APB-style configuration register file of the chunker.
// Depends on i2cec_pkg.
module i2cec_cfg import i2cec_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_dev_addr     <= RST_BASE_SLAVE;
            cfg_reg.capacity          <= RST_CAPACITY;
            cfg_reg.pg_bytes          <= RST_PG_BYTES;
            cfg_reg.addr_bytes        <= RST_WORD_BYTES;
            cfg_reg.block_select_bits <= RST_BLOCK_BITS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BASE_SLAVE: cfg_reg.base_dev_addr     <= pwdata[SLAVE_W-1:0];
                REG_CAPACITY:   cfg_reg.capacity          <= pwdata[CURSOR_W-1:0];
                REG_PG_BYTES:   cfg_reg.pg_bytes          <= pwdata[PAGE_W-1:0];
                REG_WORD_BYTES: cfg_reg.addr_bytes        <= pwdata[1:0];
                REG_BLOCK_BITS: cfg_reg.block_select_bits <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE_SLAVE: prdata = CFG_DATA_W'(cfg_reg.base_dev_addr);
            REG_CAPACITY:   prdata = CFG_DATA_W'(cfg_reg.capacity);
            REG_PG_BYTES:   prdata = CFG_DATA_W'(cfg_reg.pg_bytes);
            REG_WORD_BYTES: prdata = CFG_DATA_W'(cfg_reg.addr_bytes);
            REG_BLOCK_BITS: prdata = CFG_DATA_W'(cfg_reg.block_select_bits);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== sv/i2cec_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing FSM of the chunker: accept, check, page remainder, sizing, emit.
// Depends on i2cec_pkg; drives i2cec_dp through dp_cmd_t.
module i2cec_ctrl import i2cec_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = stat.need_chunk ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = S_CALC;
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ===== sv/i2cec_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the chunker: transfer state, range check, page remainder unit,
// chunk sizing and the output register. Depends on i2cec_pkg.
module i2cec_dp import i2cec_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [OP_W-1:0]      in_opcode,
    input  logic [ADDR_BITS-1:0] in_start_addr,
    input  logic [LEN_W-1:0]     in_length,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [STATUS_W-1:0]  out_status,
    output logic [SLAVE_W-1:0]   out_dev_addr,
    output logic [WORD_W-1:0]    out_mem_addr,
    output logic [LEN_W-1:0]     out_chunk_len,
    output logic [OFFSET_W-1:0]  out_buffer_offset,
    output logic                 out_is_write,
    output logic                 out_last
);

    localparam int CMP_W = (ADDR_BITS > CURSOR_W) ? ADDR_BITS : CURSOR_W;

    // latched input item
    logic [OP_W-1:0]      op_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LEN_W-1:0]     len_reg;

    // transfer state
    logic [CURSOR_W-1:0]  cursor_reg;
    logic [LEN_W-1:0]     left_reg;
    logic [LEN_W-1:0]     done_reg;
    logic                 wmode_reg;
    logic                 active_reg;
    logic [STATUS_W-1:0]  status_reg;

    // remainder unit
    logic [CURSOR_W-1:0]  divq_reg, divq_next;
    logic [PAGE_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] divcnt_reg;
    logic [LEN_W-1:0]     chunk_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [STATUS_W-1:0]  o_status_reg;
    logic [SLAVE_W-1:0]   o_slave_reg;
    logic [WORD_W-1:0]    o_word_reg;
    logic [LEN_W-1:0]     o_chunk_reg;
    logic [OFFSET_W-1:0]  o_offset_reg;
    logic                 o_write_reg;
    logic                 o_last_reg;

    // eval
    logic                 is_start;
    logic [CMP_W-1:0]     addr_ext;
    logic [CMP_W-1:0]     total_ext;
    logic [CURSOR_W-1:0]  addr_cur;
    logic [CURSOR_W-1:0]  room_total;
    logic                 range_ok;
    logic                 has_work;
    logic [CURSOR_W-1:0]  eff_cursor;

    // sizing and emit
    logic                 wab1;
    logic [PAGE_W:0]      pg;
    logic [PAGE_W:0]      room_pg;
    logic [16:0]          blk_off;
    logic [16:0]          room_blk;
    logic [LEN_W-1:0]     chunk_a, chunk_b;
    logic [2:0]           blk_idx;
    logic [2:0]           blk_mask;
    logic [SLAVE_W-1:0]   base_eff;
    logic [SLAVE_W-1:0]   slave;
    logic [WORD_W-1:0]    word;
    logic [LEN_W-1:0]     left_after;
    logic                 out_free;
    logic                 is_chunk;

    assign is_start   = (op_reg == OP_START_RD) || (op_reg == OP_START_WR);
    assign addr_ext   = CMP_W'(addr_reg);
    assign total_ext  = CMP_W'(cfg.capacity);
    assign addr_cur   = addr_ext[CURSOR_W-1:0];
    assign room_total = cfg.capacity - addr_cur;
    assign range_ok   = (len_reg != '0) && (addr_ext < total_ext) && (len_reg <= room_total);
    assign has_work   = active_reg && (left_reg != '0);
    assign eff_cursor = is_start ? addr_cur : cursor_reg;

    assign wab1 = (cfg.addr_bytes == 2'd1);
    assign pg   = (cfg.pg_bytes == '0) ? 9'd256 : {1'b0, cfg.pg_bytes};

    // restoring remainder, DIV_BITS cursor bits per step, MSB first
    always_comb begin
        logic [PAGE_W:0] r;
        logic [CURSOR_W-1:0] q;
        r = {1'b0, rem_reg};
        q = divq_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            r = {r[PAGE_W-1:0], q[CURSOR_W-1]};
            q = {q[CURSOR_W-2:0], 1'b0};
            if (r >= pg) r = r - pg;
        end
        rem_next  = r[PAGE_W-1:0];
        divq_next = q;
    end

    assign room_pg  = pg - {1'b0, rem_reg};
    assign blk_off  = wab1 ? {9'd0, cursor_reg[7:0]} : {1'b0, cursor_reg[15:0]};
    assign room_blk = (wab1 ? 17'h00100 : 17'h10000) - blk_off;

    always_comb begin
        chunk_a = left_reg;
        if (wmode_reg && (LEN_W'(room_pg) < chunk_a)) chunk_a = LEN_W'(room_pg);
        chunk_b = chunk_a;
        if ((cfg.block_select_bits != 2'd0) && (LEN_W'(room_blk) < chunk_b))
            chunk_b = LEN_W'(room_blk);
    end

    assign blk_idx  = wab1 ? cursor_reg[10:8] : {cursor_reg[18:16]};
    assign blk_mask = 3'((4'd1 << cfg.block_select_bits) - 4'd1);
    assign base_eff = (cfg.base_dev_addr == '0) ? DEFAULT_SLAVE : cfg.base_dev_addr;
    assign slave    = base_eff | {4'd0, blk_idx & blk_mask};
    assign word     = wab1 ? {8'd0, cursor_reg[7:0]} : cursor_reg[15:0];
    assign left_after = left_reg - chunk_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_chunk = (status_reg == STS_CHUNK);

    assign stat.need_chunk = is_start ? range_ok : has_work;
    assign stat.div_done   = (divcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_opcode;
            addr_reg <= in_start_addr;
            len_reg  <= in_length;
        end
        if (cmd.eval) begin
            divq_reg   <= eff_cursor;
            rem_reg    <= '0;
            divcnt_reg <= '0;
            if (is_start) status_reg <= range_ok ? STS_CHUNK : STS_RANGE;
            else          status_reg <= has_work ? STS_CHUNK : STS_NO_XFER;
        end
        if (cmd.div_step) begin
            divq_reg   <= divq_next;
            rem_reg    <= rem_next;
            divcnt_reg <= divcnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.calc) chunk_reg <= chunk_b;
        if (cmd.emit) begin
            o_status_reg <= status_reg;
            o_slave_reg  <= is_chunk ? slave : '0;
            o_word_reg   <= is_chunk ? word : '0;
            o_chunk_reg  <= is_chunk ? chunk_reg : '0;
            o_offset_reg <= is_chunk ? done_reg[OFFSET_W-1:0] : '0;
            o_write_reg  <= is_chunk && wmode_reg;
            o_last_reg   <= is_chunk && (chunk_reg == left_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg   <= '0;
            left_reg     <= '0;
            done_reg     <= '0;
            wmode_reg    <= 1'b0;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.eval && is_start) begin
                if (range_ok) begin
                    cursor_reg <= addr_cur;
                    left_reg   <= len_reg;
                    done_reg   <= '0;
                    wmode_reg  <= (op_reg == OP_START_WR);
                    active_reg <= 1'b1;
                end else begin
                    active_reg <= 1'b0;
                end
            end
            if (cmd.emit && is_chunk) begin
                cursor_reg <= cursor_reg + chunk_reg;
                left_reg   <= left_after;
                done_reg   <= done_reg + chunk_reg;
                if (left_after == '0) active_reg <= 1'b0;
            end
            if (cmd.emit)        m_tvalid_reg <= 1'b1;
            else if (m_tready)   m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign out_status        = o_status_reg;
    assign out_dev_addr      = o_slave_reg;
    assign out_mem_addr      = o_word_reg;
    assign out_chunk_len     = o_chunk_reg;
    assign out_buffer_offset = o_offset_reg;
    assign out_is_write      = o_write_reg;
    assign out_last          = o_last_reg;

endmodule
